/* rtl/cft_pkg.sv */
package cft_pkg;

   localparam int DataW      = 8;
   localparam int SplitW     = 8;
   localparam int ColCountW  = 7;
   localparam int CellRowW   = 16;
   localparam int CellColW   = 6;
   localparam int CellOffW   = 21;
   localparam int StatusW    = 3;
   localparam int RowTotalW  = 17;
   localparam int CsrIdxW    = 1;
   localparam int CsrDataW   = 8;

   localparam int DefMaxCols  = 64;
   localparam int DefMaxRows  = 65536;
   localparam int DefMaxBytes = 1048576;

   localparam logic [SplitW-1:0]    SplitReset    = 8'd44;
   localparam logic [ColCountW-1:0] ColCountReset = 7'd1;

   localparam logic [DataW-1:0] ChNul   = 8'd0;
   localparam logic [DataW-1:0] ChLf    = 8'd10;
   localparam logic [DataW-1:0] ChCr    = 8'd13;
   localparam logic [DataW-1:0] ChQuote = 8'd34;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPLIT_CHAR   = 1'd0,
      CSR_COLUMN_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [StatusW-1:0] {
      ST_RUNNING       = 3'd0,
      ST_DONE          = 3'd1,
      ST_TOO_MANY_COLS = 3'd2,
      ST_OPEN_QUOTE    = 3'd3,
      ST_ROW_OVERFLOW  = 3'd4,
      ST_IGNORED       = 3'd5
   } status_type;

   typedef struct packed {
      logic [DataW-1:0] data_byte;
      logic             first_byte;
      logic             last_byte;
   } req_item_type;

   typedef struct packed {
      logic [DataW-1:0]     out_byte;
      logic                 cell_start;
      logic [CellRowW-1:0]  cell_row;
      logic [CellColW-1:0]  cell_col;
      logic [CellOffW-1:0]  cell_offset;
      status_type           parse_status;
      logic [RowTotalW-1:0] row_total;
   } rsp_item_type;

endpackage

/* rtl/cft_if.sv */
interface cft_req_if;
   import cft_pkg::*;

   logic             valid;
   logic             ready;
   logic [DataW-1:0] data_byte;
   logic             first_byte;
   logic             last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

interface cft_rsp_if;
   import cft_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DataW-1:0]     out_byte;
   logic                 cell_start;
   logic [CellRowW-1:0]  cell_row;
   logic [CellColW-1:0]  cell_col;
   logic [CellOffW-1:0]  cell_offset;
   logic [StatusW-1:0]   parse_status;
   logic [RowTotalW-1:0] row_total;

   modport source (output valid, output out_byte, output cell_start, output cell_row,
                   output cell_col, output cell_offset, output parse_status,
                   output row_total, input ready);
   modport sink   (input valid, input out_byte, input cell_start, input cell_row,
                   input cell_col, input cell_offset, input parse_status,
                   input row_total, output ready);
endinterface

/* rtl/csv_field_tokenizer_top.sv */
// channel   dir   handshake          payload
// req_ch    in    valid / ready      data_byte, first_byte, last_byte
// rsp_ch    out   valid / ready      out_byte, cell_start, cell_row, cell_col,
//                                    cell_offset, parse_status, row_total
// csr       in    csr_wr_en          csr_index, csr_wdata
//
// one request per clock sustained while rsp_ch is not stalled; an accepted request reaches the response through
// the input register, then the tokenizer state update into the response register
// the per-byte state loop (quote, row, column, position) is combinational from the state registers back to them
// synchronous active-high reset clears state and restores split char 44, column count 1
// a stalled response holds; the input register takes one more request, then ready drops
module csv_field_tokenizer_top #(
   parameter int MAX_COLS  = cft_pkg::DefMaxCols,
   parameter int MAX_ROWS  = cft_pkg::DefMaxRows,
   parameter int MAX_BYTES = cft_pkg::DefMaxBytes
) (
   input  logic                         clock,
   input  logic                         reset,
   cft_req_if.sink                      req_ch,
   cft_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  cft_pkg::csr_index_type       csr_index,
   input  logic [cft_pkg::CsrDataW-1:0] csr_wdata
);
   import cft_pkg::*;

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_rsp_ff;
   rsp_item_type engine_rsp;
   logic         advance;
   logic         req_take;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   cft_engine #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .MAX_BYTES (MAX_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (s1_item_ff),
      .advance   (advance),
      .result    (engine_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.data_byte  <= req_ch.data_byte;
         s1_item_ff.first_byte <= req_ch.first_byte;
         s1_item_ff.last_byte  <= req_ch.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= engine_rsp;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_byte     = out_rsp_ff.out_byte;
   assign rsp_ch.cell_start   = out_rsp_ff.cell_start;
   assign rsp_ch.cell_row     = out_rsp_ff.cell_row;
   assign rsp_ch.cell_col     = out_rsp_ff.cell_col;
   assign rsp_ch.cell_offset  = out_rsp_ff.cell_offset;
   assign rsp_ch.parse_status = out_rsp_ff.parse_status;
   assign rsp_ch.row_total    = out_rsp_ff.row_total;

endmodule

/* rtl/cft_engine.sv */
module cft_engine #(
   parameter int MAX_COLS  = cft_pkg::DefMaxCols,
   parameter int MAX_ROWS  = cft_pkg::DefMaxRows,
   parameter int MAX_BYTES = cft_pkg::DefMaxBytes
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  cft_pkg::csr_index_type         csr_index,
   input  logic [cft_pkg::CsrDataW-1:0]   csr_wdata,
   input  cft_pkg::req_item_type          item,
   input  logic                           advance,
   output cft_pkg::rsp_item_type          result
);
   import cft_pkg::*;

   localparam int MaxColW = $clog2(MAX_COLS + 1);
   localparam int LimW    = (ColCountW > MaxColW) ? ColCountW : MaxColW;
   localparam int LimXW   = LimW + 1;
   localparam int RowW    = $clog2(MAX_ROWS + 1);
   localparam int RowXW   = RowW + 1;
   localparam int PosW    = $clog2(MAX_BYTES + 1);

   logic [SplitW-1:0]    split_ff;
   logic [ColCountW-1:0] col_count_ff;

   logic            quote_ff, quote_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [LimW-1:0] col_ff, col_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            done_ff, done_in;

   logic            quote_e, done_e;
   logic [RowW-1:0] row_e;
   logic [LimW-1:0] col_e;
   logic [PosW-1:0] pos_e;

   logic [LimW-1:0]  limit;
   logic [PosW-1:0]  next_off;
   logic [RowXW-1:0] row_inc;
   logic             row_full;
   logic [LimXW-1:0] col_inc;

   logic [DataW-1:0] ob;
   logic             start;
   logic [RowW-1:0]  srow;
   logic [LimW-1:0]  scol;
   logic [PosW-1:0]  soff;
   status_type       status;

   // state as seen by this request, cleared on the first byte of a buffer
   always_comb begin
      quote_e = item.first_byte ? 1'b0 : quote_ff;
      row_e   = item.first_byte ? '0 : row_ff;
      col_e   = item.first_byte ? '0 : col_ff;
      pos_e   = item.first_byte ? '0 : pos_ff;
      done_e  = item.first_byte ? 1'b0 : done_ff;
   end

   always_comb begin
      limit    = (LimW'(col_count_ff) < LimW'(MAX_COLS)) ? LimW'(col_count_ff)
                                                          : LimW'(MAX_COLS);
      next_off = (pos_e < PosW'(MAX_BYTES)) ? pos_e + 1'b1 : PosW'(MAX_BYTES);
      row_inc  = {1'b0, row_e} + 1'b1;
      row_full = row_inc >= RowXW'(MAX_ROWS);
   end

   always_comb begin
      ob       = item.data_byte;
      start    = 1'b0;
      srow     = '0;
      scol     = '0;
      soff     = '0;
      status   = ST_RUNNING;
      quote_in = quote_e;
      row_in   = row_e;
      col_in   = col_e;
      pos_in   = pos_e;
      done_in  = done_e;
      col_inc  = '0;
      if (done_e) begin
         status = ST_IGNORED;
      end else begin
         if (item.data_byte == split_ff) begin
            if (!quote_e && pos_e != '0) begin
               ob     = ChNul;
               col_in = col_e + 1'b1;
               if (col_in < limit) begin
                  start = 1'b1;
                  srow  = row_e;
                  scol  = col_in;
                  soff  = next_off;
               end
            end
         end else if (item.data_byte == ChNul) begin
            status  = ST_DONE;
            done_in = 1'b1;
         end else if (item.data_byte == ChCr) begin
            ob = ChNul;
         end else if (item.data_byte == ChLf) begin
            if (!quote_e && pos_e != '0) begin
               ob     = ChNul;
               col_in = '0;
               if (row_full) begin
                  status  = ST_ROW_OVERFLOW;
                  done_in = 1'b1;
               end else begin
                  row_in = RowW'(row_inc);
                  if (limit != '0) begin
                     start = 1'b1;
                     srow  = RowW'(row_inc);
                     scol  = '0;
                     soff  = next_off;
                  end
               end
            end
         end else if (item.data_byte == ChQuote) begin
            if (!quote_e && col_e < limit) begin
               start = 1'b1;
               srow  = row_e;
               scol  = col_e;
               soff  = next_off;
            end
            ob       = ChNul;
            quote_in = !quote_e;
         end

         // column limit reached
         if (!done_in && col_in >= limit) begin
            status  = ST_TOO_MANY_COLS;
            done_in = 1'b1;
            start   = 1'b0;
            srow    = '0;
            scol    = '0;
            soff    = '0;
            if (col_in != '0) begin
               col_in = (limit != '0) ? limit - 1'b1 : '0;
            end
         end

         pos_in = next_off;

         // end of buffer checks
         if (!done_in && item.last_byte) begin
            if (quote_in) begin
               status = ST_OPEN_QUOTE;
            end else begin
               col_inc = {1'b0, col_in} + 1'b1;
               if (col_inc == LimXW'(col_count_ff)) begin
                  row_in = row_in + 1'b1;
               end
               status = ST_DONE;
            end
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.out_byte     = ob;
      result.cell_start   = start;
      result.cell_row     = CellRowW'(srow);
      result.cell_col     = CellColW'(scol);
      result.cell_offset  = CellOffW'(soff);
      result.parse_status = status;
      result.row_total    = RowTotalW'(row_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff     <= SplitReset;
         col_count_ff <= ColCountReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SPLIT_CHAR: begin
               split_ff <= csr_wdata[SplitW-1:0];
            end
            CSR_COLUMN_COUNT: begin
               col_count_ff <= csr_wdata[ColCountW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (advance) begin
         quote_ff <= quote_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

endmodule
